### src/lsmc_pkg.sv
// Shared types and constants for the link status mood classifier.
// Used by lsmc_regs, lsmc_core and link_status_mood_classifier_unit.
package lsmc_pkg;

	// Register port geometry: 64-bit data, registers at 8-byte spacing
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;
	localparam int REG_IDX_W  = 3;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_BUSY_ENTER = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BUSY_EXIT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_IDLE_RATE  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_IDLE_POLLS = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_STABLE     = 3'd4;

	// Field widths
	localparam int RATE_W  = 32;
	localparam int THR_W   = 33;
	localparam int IDLE_W  = 14;
	localparam int STAB_W  = 4;
	localparam int RSRP_W  = 16;
	localparam int SINR_W  = 8;
	localparam int CARR_W  = 4;
	localparam int CLNT_W  = 8;
	localparam int RADIO_W = 8;
	localparam int MOOD_W  = 3;
	localparam int EVT_W   = 3;

	// Register reset values
	localparam logic [THR_W-1:0]  RST_BUSY_ENTER = 33'd250000;
	localparam logic [THR_W-1:0]  RST_BUSY_EXIT  = 33'd120000;
	localparam logic [THR_W-1:0]  RST_IDLE_RATE  = 33'd150000;
	localparam logic [IDLE_W-1:0] RST_IDLE_POLLS = 14'd75;
	localparam logic [STAB_W-1:0] RST_STABLE     = 4'd2;

	// Mood codes
	localparam logic [MOOD_W-1:0] MOOD_HAPPY     = 3'd0;
	localparam logic [MOOD_W-1:0] MOOD_GRIN      = 3'd1;
	localparam logic [MOOD_W-1:0] MOOD_BUSY      = 3'd2;
	localparam logic [MOOD_W-1:0] MOOD_SURPRISED = 3'd3;
	localparam logic [MOOD_W-1:0] MOOD_OFFLINE   = 3'd4;
	localparam logic [MOOD_W-1:0] MOOD_SLEEPY    = 3'd5;
	localparam logic [MOOD_W-1:0] MOOD_WILT      = 3'd6;

	// Event codes
	localparam logic [EVT_W-1:0] EVT_NONE         = 3'd0;
	localparam logic [EVT_W-1:0] EVT_MORE_CLIENTS = 3'd1;
	localparam logic [EVT_W-1:0] EVT_BACK_ONLINE  = 3'd2;
	localparam logic [EVT_W-1:0] EVT_CARRIERS_UP  = 3'd3;
	localparam logic [EVT_W-1:0] EVT_CARRIERS_DN  = 3'd4;
	localparam logic [EVT_W-1:0] EVT_RADIO_CHANGE = 3'd5;

	// Signal thresholds
	localparam logic signed [RSRP_W-1:0] RSRP_VALID_HI = -16'sd30;
	localparam logic signed [RSRP_W-1:0] RSRP_VALID_LO = -16'sd150;
	localparam logic signed [RSRP_W-1:0] RSRP_GRIN_EXIT = -16'sd95;
	localparam logic signed [RSRP_W-1:0] RSRP_WILT_EXIT = -16'sd100;
	localparam logic signed [RSRP_W-1:0] RSRP_GRIN_ENTER = -16'sd90;
	localparam logic signed [RSRP_W-1:0] RSRP_WILT_ENTER = -16'sd107;
	localparam logic signed [SINR_W-1:0] SINR_GRIN_EXIT = 8'sd10;
	localparam logic signed [SINR_W-1:0] SINR_WILT_EXIT = 8'sd8;
	localparam logic signed [SINR_W-1:0] SINR_GRIN_ENTER = 8'sd12;
	localparam logic signed [SINR_W-1:0] SINR_WILT_ENTER = 8'sd5;

	// Held signal reset values
	localparam logic signed [RSRP_W-1:0] RST_HELD_RSRP = -16'sd90;
	localparam logic signed [SINR_W-1:0] RST_HELD_SINR = 8'sd10;

	localparam logic [IDLE_W-1:0] IDLE_CAP = 14'd9999;
	localparam logic [STAB_W-1:0] CAND_CAP = 4'd15;

	typedef struct packed {
		logic [THR_W-1:0]  busy_enter_rate;
		logic [THR_W-1:0]  busy_exit_rate;
		logic [THR_W-1:0]  idle_rate_limit;
		logic [IDLE_W-1:0] idle_polls_to_sleep;
		logic [STAB_W-1:0] stable_polls;
	} cfg_t;

	typedef struct packed {
		logic                     link_online;
		logic [RATE_W-1:0]        down_rate;
		logic [RATE_W-1:0]        up_rate;
		logic signed [RSRP_W-1:0] rsrp_raw;
		logic signed [SINR_W-1:0] sinr_raw;
		logic                     recent_activity;
		logic [CARR_W-1:0]        carrier_count;
		logic [CLNT_W-1:0]        client_count;
		logic [RADIO_W-1:0]       radio_tech_code;
	} poll_t;

	typedef struct packed {
		logic [MOOD_W-1:0] mood_code;
		logic [EVT_W-1:0]  event_kind;
		logic [RATE_W-1:0] peak_rate;
		logic              peak_is_upload;
	} result_t;

endpackage

### src/lsmc_regs.sv
// Configuration register file of the mood classifier, APB-style access.
// Depends on lsmc_pkg for register indexes, reset values and cfg_t.
module lsmc_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lsmc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [lsmc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [lsmc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready,
	output lsmc_pkg::cfg_t                 cfg
);
	import lsmc_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Write the addressed register in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.busy_enter_rate     <= RST_BUSY_ENTER;
			cfg_q.busy_exit_rate      <= RST_BUSY_EXIT;
			cfg_q.idle_rate_limit     <= RST_IDLE_RATE;
			cfg_q.idle_polls_to_sleep <= RST_IDLE_POLLS;
			cfg_q.stable_polls        <= RST_STABLE;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BUSY_ENTER: cfg_q.busy_enter_rate     <= pwdata[THR_W-1:0];
				REG_BUSY_EXIT:  cfg_q.busy_exit_rate      <= pwdata[THR_W-1:0];
				REG_IDLE_RATE:  cfg_q.idle_rate_limit     <= pwdata[THR_W-1:0];
				REG_IDLE_POLLS: cfg_q.idle_polls_to_sleep <= pwdata[IDLE_W-1:0];
				REG_STABLE:     cfg_q.stable_polls        <= pwdata[STAB_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register, zero-extended
	always_comb begin
		unique case (reg_idx)
			REG_BUSY_ENTER: prdata = {{(CFG_DATA_W-THR_W){1'b0}}, cfg_q.busy_enter_rate};
			REG_BUSY_EXIT:  prdata = {{(CFG_DATA_W-THR_W){1'b0}}, cfg_q.busy_exit_rate};
			REG_IDLE_RATE:  prdata = {{(CFG_DATA_W-THR_W){1'b0}}, cfg_q.idle_rate_limit};
			REG_IDLE_POLLS: prdata = {{(CFG_DATA_W-IDLE_W){1'b0}}, cfg_q.idle_polls_to_sleep};
			REG_STABLE:     prdata = {{(CFG_DATA_W-STAB_W){1'b0}}, cfg_q.stable_polls};
			default:        prdata = '0;
		endcase
	end

endmodule

### src/lsmc_core.sv
// Classifier state and per-poll decision logic: busy and signal hysteresis,
// idle counting, mood debounce and change events. Depends on lsmc_pkg.
module lsmc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  lsmc_pkg::poll_t   poll,
	input  lsmc_pkg::cfg_t    cfg,
	output lsmc_pkg::result_t res
);
	import lsmc_pkg::*;

	// State
	logic                     busy_q;
	logic [MOOD_W-1:0]        level_q;
	logic signed [RSRP_W-1:0] held_rsrp_q;
	logic signed [SINR_W-1:0] held_sinr_q;
	logic [IDLE_W-1:0]        idle_q;
	logic [MOOD_W-1:0]        shown_q;
	logic [MOOD_W-1:0]        cand_q;
	logic [STAB_W-1:0]        cand_cnt_q;
	logic                     seen_q;
	logic                     last_online_q;
	logic [CARR_W-1:0]        last_carr_q;
	logic [CLNT_W-1:0]        last_clnt_q;
	logic [RADIO_W-1:0]       last_radio_q;

	// Next-state terms
	logic [THR_W-1:0]         thr;
	logic                     rsrp_ok;
	logic signed [RSRP_W-1:0] hr;
	logic signed [SINR_W-1:0] hs;
	logic                     busy_d;
	logic [MOOD_W-1:0]        level_d;
	logic [MOOD_W-1:0]        target;
	logic [IDLE_W-1:0]        idle_d;
	logic [MOOD_W-1:0]        final_tgt;
	logic [STAB_W-1:0]        cnt_tmp;
	logic [MOOD_W-1:0]        shown_d;
	logic [MOOD_W-1:0]        cand_d;
	logic [STAB_W-1:0]        cand_cnt_d;
	logic [EVT_W-1:0]         evt;

	// Combined throughput and held signal
	assign thr     = {1'b0, poll.down_rate} + {1'b0, poll.up_rate};
	assign rsrp_ok = (poll.rsrp_raw <= RSRP_VALID_HI) && (poll.rsrp_raw >= RSRP_VALID_LO);
	assign hr      = rsrp_ok ? poll.rsrp_raw : held_rsrp_q;
	assign hs      = rsrp_ok ? poll.sinr_raw : held_sinr_q;

	// Busy hysteresis
	assign busy_d = busy_q ? !(thr < cfg.busy_exit_rate) : (thr > cfg.busy_enter_rate);

	// Three-level signal hysteresis
	always_comb begin
		case (level_q)
			MOOD_GRIN: begin
				level_d = (hr < RSRP_GRIN_EXIT && hs < SINR_GRIN_EXIT) ? MOOD_HAPPY : MOOD_GRIN;
			end
			MOOD_WILT: begin
				level_d = (hr > RSRP_WILT_EXIT || hs > SINR_WILT_EXIT) ? MOOD_HAPPY : MOOD_WILT;
			end
			default: begin
				if (hr >= RSRP_GRIN_ENTER || hs >= SINR_GRIN_ENTER) begin
					level_d = MOOD_GRIN;
				end else if (hr < RSRP_WILT_ENTER && hs < SINR_WILT_ENTER) begin
					level_d = MOOD_WILT;
				end else begin
					level_d = MOOD_HAPPY;
				end
			end
		endcase
	end

	always_comb begin
		if (!poll.link_online) begin
			target = MOOD_OFFLINE;
		end else if (busy_d) begin
			target = MOOD_BUSY;
		end else begin
			target = level_d;
		end
	end

	// Idle counting, saturating
	always_comb begin
		if (poll.recent_activity) begin
			idle_d = '0;
		end else if ((target == MOOD_HAPPY || target == MOOD_GRIN)
			&& thr < cfg.idle_rate_limit) begin
			idle_d = (idle_q < IDLE_CAP) ? idle_q + 1'b1 : idle_q;
		end else begin
			idle_d = '0;
		end
	end

	assign final_tgt = (target != MOOD_OFFLINE && idle_d >= cfg.idle_polls_to_sleep)
		? MOOD_SLEEPY : target;

	// Debounce mood changes; offline shows at once
	always_comb begin
		cnt_tmp = (final_tgt == cand_q)
			? ((cand_cnt_q == CAND_CAP) ? cand_cnt_q : cand_cnt_q + 1'b1)
			: {{(STAB_W-1){1'b0}}, 1'b1};
		if (final_tgt == MOOD_OFFLINE || final_tgt == shown_q) begin
			shown_d    = final_tgt;
			cand_d     = cand_q;
			cand_cnt_d = '0;
		end else begin
			cand_d = final_tgt;
			if (cnt_tmp >= cfg.stable_polls) begin
				shown_d    = final_tgt;
				cand_cnt_d = '0;
			end else begin
				shown_d    = shown_q;
				cand_cnt_d = cnt_tmp;
			end
		end
	end

	// Change event against the previous poll, first match wins
	always_comb begin
		evt = EVT_NONE;
		if (seen_q) begin
			if (poll.client_count > last_clnt_q) begin
				evt = EVT_MORE_CLIENTS;
			end else if (poll.link_online && !last_online_q) begin
				evt = EVT_BACK_ONLINE;
			end else if (poll.carrier_count != last_carr_q && poll.carrier_count != '0
				&& last_carr_q != '0) begin
				evt = (poll.carrier_count > last_carr_q) ? EVT_CARRIERS_UP : EVT_CARRIERS_DN;
			end else if (poll.radio_tech_code != '0 && last_radio_q != '0
				&& poll.radio_tech_code != last_radio_q) begin
				evt = EVT_RADIO_CHANGE;
			end
		end
	end

	assign res.mood_code      = shown_d;
	assign res.event_kind     = evt;
	assign res.peak_rate      = (poll.down_rate >= poll.up_rate) ? poll.down_rate : poll.up_rate;
	assign res.peak_is_upload = poll.up_rate > poll.down_rate;

	// Advance state once per processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			level_q       <= MOOD_HAPPY;
			held_rsrp_q   <= RST_HELD_RSRP;
			held_sinr_q   <= RST_HELD_SINR;
			idle_q        <= '0;
			shown_q       <= MOOD_HAPPY;
			cand_q        <= MOOD_HAPPY;
			cand_cnt_q    <= '0;
			seen_q        <= 1'b0;
			last_online_q <= 1'b1;
			last_carr_q   <= '0;
			last_clnt_q   <= '0;
			last_radio_q  <= '0;
		end else if (advance) begin
			if (poll.link_online) begin
				busy_q      <= busy_d;
				held_rsrp_q <= hr;
				held_sinr_q <= hs;
				if (!busy_d) begin
					level_q <= level_d;
				end
			end
			idle_q        <= idle_d;
			shown_q       <= shown_d;
			cand_q        <= cand_d;
			cand_cnt_q    <= cand_cnt_d;
			seen_q        <= 1'b1;
			last_online_q <= poll.link_online;
			last_carr_q   <= poll.carrier_count;
			last_clnt_q   <= poll.client_count;
			last_radio_q  <= poll.radio_tech_code;
		end
	end

	a_idle_capped: assert property (@(posedge clk) disable iff (!arst_n)
		idle_q <= IDLE_CAP)
		else $error("idle count above cap");

	a_offline_shown: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !poll.link_online |=> shown_q == MOOD_OFFLINE)
		else $error("offline poll not shown at once");

	a_level_legal: assert property (@(posedge clk) disable iff (!arst_n)
		level_q == MOOD_HAPPY || level_q == MOOD_GRIN || level_q == MOOD_WILT)
		else $error("signal level left its three codes");

	a_shown_legal: assert property (@(posedge clk) disable iff (!arst_n)
		shown_q != MOOD_SURPRISED && shown_q != 3'd7)
		else $error("shown mood holds an unused code");

endmodule

### src/link_status_mood_classifier_unit.sv
// Top level of the link status mood classifier: input word register,
// result register and handshake. Depends on lsmc_pkg, lsmc_regs, lsmc_core.
//
// Use:
//   Input channel: one status poll per word on in_valid / in_stall, taken at an
//   edge with in_valid high and in_stall low. Output channel: one result word
//   (mood, event, peak rate) per poll on out_valid / out_stall, in poll order.
//   Registers sit at byte addresses 8*i on the APB-style port; write them only
//   while no poll is in flight. pready is tied high.
//   An accepted poll stays in the input register until its result is loaded
//   into the result register that drives out_valid. Throughput: one poll per
//   cycle while out_stall is low; the decision logic between the registers is
//   combinational, and the classifier state is updated as the result loads.
//   Stall: while out_stall holds a pending result, the input register keeps
//   its word and in_stall goes high once that register is full too.
//   Reset: arst_n clears both valid flags, the classifier state and the
//   registers to their defaults; the first poll after reset reports no event.
module link_status_mood_classifier_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Poll channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  link_online,
	input  logic [lsmc_pkg::RATE_W-1:0]           down_rate,
	input  logic [lsmc_pkg::RATE_W-1:0]           up_rate,
	input  logic signed [lsmc_pkg::RSRP_W-1:0]    rsrp_raw,
	input  logic signed [lsmc_pkg::SINR_W-1:0]    sinr_raw,
	input  logic                                  recent_activity,
	input  logic [lsmc_pkg::CARR_W-1:0]           carrier_count,
	input  logic [lsmc_pkg::CLNT_W-1:0]           client_count,
	input  logic [lsmc_pkg::RADIO_W-1:0]          radio_tech_code,
	// Result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [lsmc_pkg::MOOD_W-1:0]           mood_code,
	output logic [lsmc_pkg::EVT_W-1:0]            event_kind,
	output logic [lsmc_pkg::RATE_W-1:0]           peak_rate,
	output logic                                  peak_is_upload,
	// Register port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [lsmc_pkg::CFG_ADDR_W-1:0]       paddr,
	input  logic [lsmc_pkg::CFG_DATA_W-1:0]       pwdata,
	output logic [lsmc_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                  pready
);
	import lsmc_pkg::*;

	cfg_t    cfg;
	poll_t   poll_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    in_take;

	lsmc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Process the held word when the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign in_take  = in_valid && !in_stall;

	// Input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			poll_s1.link_online     <= link_online;
			poll_s1.down_rate       <= down_rate;
			poll_s1.up_rate         <= up_rate;
			poll_s1.rsrp_raw        <= rsrp_raw;
			poll_s1.sinr_raw        <= sinr_raw;
			poll_s1.recent_activity <= recent_activity;
			poll_s1.carrier_count   <= carrier_count;
			poll_s1.client_count    <= client_count;
			poll_s1.radio_tech_code <= radio_tech_code;
		end
	end

	lsmc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.poll    (poll_s1),
		.cfg     (cfg),
		.res     (res_d)
	);

	// Result register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid      = valid_s2;
	assign mood_code      = res_s2.mood_code;
	assign event_kind     = res_s2.event_kind;
	assign peak_rate      = res_s2.peak_rate;
	assign peak_is_upload = res_s2.peak_is_upload;

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("processed word did not reach the result register");

	a_held_word_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(poll_s1))
		else $error("unprocessed input word lost or changed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |-> !advance)
		else $error("pending result overwritten");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for link_status_mood_classifier_unit: a directed table, then
// random poll sequences, checked word by word against an in-file mood predictor.
// Depends on lsmc_pkg and the RTL under src.
module tb;
	import lsmc_pkg::*;

	localparam int STUCK_LIMIT = 4000;
	localparam int QUIET_RUN = 50;
	localparam logic [THR_W-1:0] RATE_TOP = '1;

	typedef struct packed {
		poll_t   poll;
		logic    typed;
		result_t want;
	} plan_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic                     link_online;
	logic [RATE_W-1:0]        down_rate;
	logic [RATE_W-1:0]        up_rate;
	logic signed [RSRP_W-1:0] rsrp_raw;
	logic signed [SINR_W-1:0] sinr_raw;
	logic                     recent_activity;
	logic [CARR_W-1:0]        carrier_count;
	logic [CLNT_W-1:0]        client_count;
	logic [RADIO_W-1:0]       radio_tech_code;
	logic                     out_valid;
	logic                     out_stall;
	logic [MOOD_W-1:0]        mood_code;
	logic [EVT_W-1:0]         event_kind;
	logic [RATE_W-1:0]        peak_rate;
	logic                     peak_is_upload;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_W-1:0]    paddr;
	logic [CFG_DATA_W-1:0]    pwdata;
	logic [CFG_DATA_W-1:0]    prdata;
	logic                     pready;

	link_status_mood_classifier_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.link_online(link_online), .down_rate(down_rate), .up_rate(up_rate),
		.rsrp_raw(rsrp_raw), .sinr_raw(sinr_raw), .recent_activity(recent_activity),
		.carrier_count(carrier_count), .client_count(client_count),
		.radio_tech_code(radio_tech_code),
		.out_valid(out_valid), .out_stall(out_stall),
		.mood_code(mood_code), .event_kind(event_kind),
		.peak_rate(peak_rate), .peak_is_upload(peak_is_upload),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	// Predictor copy of the registers and classifier state
	cfg_t                     cfg;
	logic                     is_busy;
	logic [MOOD_W-1:0]        signal_band;
	logic signed [RSRP_W-1:0] rsrp_hold;
	logic signed [SINR_W-1:0] sinr_hold;
	logic [IDLE_W-1:0]        quiet_polls;
	logic [MOOD_W-1:0]        face_mood;
	logic [MOOD_W-1:0]        pending_mood;
	logic [STAB_W-1:0]        pending_run;
	logic                     primed;
	logic                     link_was_up;
	logic [CARR_W-1:0]        prev_carriers;
	logic [CLNT_W-1:0]        clients_before;
	logic [RADIO_W-1:0]       prev_radio;

	result_t pending_results[$];
	int      polls_taken = 0;
	int      results_seen = 0;
	int      fails = 0;

	// Sender and receiver idling state
	int      send_dense_left = 0;
	int      free_left = 0;
	int      stall_left = 0;
	int      hold_left = 0;
	bit      held_once = 1'b0;
	logic    result_ready;
	result_t result_word;

	// Advance the classifier by one poll and return the word it should produce
	function automatic result_t classify_poll(input poll_t p);
		logic [THR_W-1:0]         total;
		logic signed [RSRP_W-1:0] rr;
		logic [MOOD_W-1:0]        goal;
		result_t                  r;
		total = {1'b0, p.down_rate} + {1'b0, p.up_rate};
		rr = p.rsrp_raw;
		r.event_kind = EVT_NONE;
		if (!p.link_online) begin
			goal = MOOD_OFFLINE;
		end else begin
			// hold the signal report only when rsrp is plausible
			if (rr <= RSRP_VALID_HI && rr >= RSRP_VALID_LO) begin
				rsrp_hold = rr;
				sinr_hold = p.sinr_raw;
			end
			if (is_busy) begin
				if (total < cfg.busy_exit_rate) is_busy = 1'b0;
			end else if (total > cfg.busy_enter_rate) begin
				is_busy = 1'b1;
			end
			if (is_busy) begin
				goal = MOOD_BUSY;
			end else begin
				if (signal_band == MOOD_GRIN) begin
					if (rsrp_hold < RSRP_GRIN_EXIT && sinr_hold < SINR_GRIN_EXIT)
						signal_band = MOOD_HAPPY;
				end else if (signal_band == MOOD_WILT) begin
					if (rsrp_hold > RSRP_WILT_EXIT || sinr_hold > SINR_WILT_EXIT)
						signal_band = MOOD_HAPPY;
				end else if (rsrp_hold >= RSRP_GRIN_ENTER || sinr_hold >= SINR_GRIN_ENTER) begin
					signal_band = MOOD_GRIN;
				end else if (rsrp_hold < RSRP_WILT_ENTER && sinr_hold < SINR_WILT_ENTER) begin
					signal_band = MOOD_WILT;
				end else begin
					signal_band = MOOD_HAPPY;
				end
				goal = signal_band;
			end
		end

		// count quiet polls towards sleepy, saturating at the cap
		if (p.recent_activity) begin
			quiet_polls = '0;
		end else if ((goal == MOOD_HAPPY || goal == MOOD_GRIN) && total < cfg.idle_rate_limit) begin
			if (quiet_polls < IDLE_CAP) quiet_polls = quiet_polls + 1'b1;
		end else begin
			quiet_polls = '0;
		end
		if (goal != MOOD_OFFLINE && quiet_polls >= cfg.idle_polls_to_sleep) goal = MOOD_SLEEPY;

		// offline shows at once; other moods need enough agreeing polls
		if (goal == MOOD_OFFLINE || goal == face_mood) begin
			face_mood = goal;
			pending_run = '0;
		end else begin
			if (goal == pending_mood) begin
				if (pending_run < CAND_CAP) pending_run = pending_run + 1'b1;
			end else begin
				pending_mood = goal;
				pending_run = STAB_W'(1);
			end
			if (pending_run >= cfg.stable_polls) begin
				face_mood = goal;
				pending_run = '0;
			end
		end

		// compare with the previous poll; first match wins
		if (primed) begin
			if (p.client_count > clients_before)
				r.event_kind = EVT_MORE_CLIENTS;
			else if (p.link_online && !link_was_up)
				r.event_kind = EVT_BACK_ONLINE;
			else if (p.carrier_count != prev_carriers && p.carrier_count != 0 && prev_carriers != 0)
				r.event_kind = (p.carrier_count > prev_carriers) ? EVT_CARRIERS_UP : EVT_CARRIERS_DN;
			else if (p.radio_tech_code != 0 && prev_radio != 0 && p.radio_tech_code != prev_radio)
				r.event_kind = EVT_RADIO_CHANGE;
		end
		link_was_up = p.link_online;
		prev_carriers = p.carrier_count;
		clients_before = p.client_count;
		prev_radio = p.radio_tech_code;
		primed = 1'b1;

		r.mood_code = face_mood;
		r.peak_rate = (p.down_rate >= p.up_rate) ? p.down_rate : p.up_rate;
		r.peak_is_upload = p.up_rate > p.down_rate;
		return r;
	endfunction

	function automatic poll_t poll_of(input logic on, input logic [RATE_W-1:0] dl,
			input logic [RATE_W-1:0] ul, input int rsrp, input int sinr, input logic act,
			input int carr, input int cli, input int radio);
		poll_t p;
		p.link_online = on;
		p.down_rate = dl;
		p.up_rate = ul;
		p.rsrp_raw = RSRP_W'(rsrp);
		p.sinr_raw = SINR_W'(sinr);
		p.recent_activity = act;
		p.carrier_count = CARR_W'(carr);
		p.client_count = CLNT_W'(cli);
		p.radio_tech_code = RADIO_W'(radio);
		return p;
	endfunction

	// Random poll with rates and signal mostly clustered around the live thresholds
	function automatic poll_t fresh_poll();
		poll_t  p;
		longint sum;
		longint part;
		int     rr;
		int     ss;
		p.link_online = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 9))
			0, 1: sum = $urandom_range(0, 1000);
			2: sum = longint'($urandom) + longint'($urandom);
			3, 4: sum = longint'(cfg.busy_enter_rate) + $urandom_range(0, 6) - 3;
			5, 6: sum = longint'(cfg.busy_exit_rate) + $urandom_range(0, 6) - 3;
			default: sum = longint'(cfg.idle_rate_limit) + $urandom_range(0, 6) - 3;
		endcase
		if (sum < 0) sum = 0;
		if (sum > 64'h1_FFFF_FFFE) sum = 64'h1_FFFF_FFFE;
		if (sum > 64'hFFFF_FFFF) part = 64'hFFFF_FFFF;
		else part = sum * $urandom_range(0, 100) / 100;
		if ($urandom_range(0, 1) == 0) begin
			p.down_rate = RATE_W'(part);
			p.up_rate = RATE_W'(sum - part);
		end else begin
			p.up_rate = RATE_W'(part);
			p.down_rate = RATE_W'(sum - part);
		end
		case ($urandom_range(0, 5))
			0: rr = $urandom_range(0, 65535);
			1: begin
				case ($urandom_range(0, 5))
					0: rr = -150;
					1: rr = -30;
					2: rr = -95;
					3: rr = -100;
					4: rr = -90;
					default: rr = -107;
				endcase
				rr = rr + int'($urandom_range(0, 2)) - 1;
			end
			default: rr = -int'($urandom_range(30, 150));
		endcase
		case ($urandom_range(0, 4))
			0: ss = $urandom_range(0, 255);
			1: ss = int'($urandom_range(0, 3)) * 2 + 5 + int'($urandom_range(0, 2)) - 1;
			default: ss = int'($urandom_range(0, 35)) - 10;
		endcase
		p.rsrp_raw = RSRP_W'(rr);
		p.sinr_raw = SINR_W'(ss);
		p.recent_activity = ($urandom_range(0, 3) == 0);
		p.carrier_count = ($urandom_range(0, 4) == 0) ? '0 : CARR_W'($urandom_range(1, 15));
		p.client_count = CLNT_W'($urandom_range(0, 255));
		p.radio_tech_code = ($urandom_range(0, 3) == 0) ? '0 : RADIO_W'($urandom_range(1, 255));
		return p;
	endfunction

	// Sender gap: mostly short, a few long, with stretches of back-to-back words
	function automatic int sender_gap();
		if (send_dense_left > 0) begin
			send_dense_left--;
			return 0;
		end
		case ($urandom_range(0, 19))
			0: begin
				send_dense_left = $urandom_range(10, 40);
				return 0;
			end
			1: return $urandom_range(12, 40);
			2, 3, 4: return $urandom_range(3, 8);
			5, 6, 7, 8, 9, 10: return $urandom_range(1, 2);
			default: return 0;
		endcase
	endfunction

	// Offer one poll word and hold it until the block takes it
	task automatic offer_poll(input poll_t p, input logic typed, input result_t want);
		int      gap;
		bit      taken;
		result_t guess;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		{link_online, down_rate, up_rate, rsrp_raw, sinr_raw, recent_activity,
			carrier_count, client_count, radio_tech_code} <= p;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		guess = classify_poll(p);
		pending_results.push_back(typed ? want : guess);
		polls_taken++;
	endtask

	// Drop valid and wait until every outstanding result is back
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_setting(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		bit rdy;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BUSY_ENTER: cfg.busy_enter_rate = val[THR_W-1:0];
			REG_BUSY_EXIT: cfg.busy_exit_rate = val[THR_W-1:0];
			REG_IDLE_RATE: cfg.idle_rate_limit = val[THR_W-1:0];
			REG_IDLE_POLLS: cfg.idle_polls_to_sleep = val[IDLE_W-1:0];
			REG_STABLE: cfg.stable_polls = val[STAB_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [THR_W-1:0] enter_rate,
			input logic [THR_W-1:0] leave_rate, input logic [THR_W-1:0] idle_rate,
			input logic [IDLE_W-1:0] sleep_polls, input logic [STAB_W-1:0] agree_polls);
		write_setting(REG_BUSY_ENTER, CFG_DATA_W'(enter_rate));
		write_setting(REG_BUSY_EXIT, CFG_DATA_W'(leave_rate));
		write_setting(REG_IDLE_RATE, CFG_DATA_W'(idle_rate));
		write_setting(REG_IDLE_POLLS, CFG_DATA_W'(sleep_polls));
		write_setting(REG_STABLE, CFG_DATA_W'(agree_polls));
	endtask

	// Runs of similar polls with small mutations, plus some pure noise
	task automatic random_polls(input int count);
		poll_t        base;
		poll_t        p;
		poll_t        spare;
		logic [127:0] noise;
		int           left;
		int           run;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				noise = {$urandom, $urandom, $urandom, $urandom};
				offer_poll(noise[$bits(poll_t)-1:0], 1'b0, '0);
				left--;
			end else begin
				base = fresh_poll();
				run = $urandom_range(1, 12);
				while (run > 0 && left > 0) begin
					p = base;
					if ($urandom_range(0, 2) == 0) begin
						spare = fresh_poll();
						case ($urandom_range(0, 4))
							0: begin
								p.down_rate = spare.down_rate;
								p.up_rate = spare.up_rate;
							end
							1: begin
								p.rsrp_raw = spare.rsrp_raw;
								p.sinr_raw = spare.sinr_raw;
							end
							2: p.link_online = spare.link_online;
							3: p.recent_activity = spare.recent_activity;
							default: begin
								p.carrier_count = spare.carrier_count;
								p.client_count = spare.client_count;
								p.radio_tech_code = spare.radio_tech_code;
							end
						endcase
					end
					offer_poll(p, 1'b0, '0);
					run--;
					left--;
				end
			end
		end
	endtask

	// Long run of quiet polls with a good signal, to walk the idle count up to sleepy
	task automatic quiet_stretch(input int count);
		poll_t p;
		repeat (count) begin
			p = poll_of(1'b1, $urandom, $urandom, -int'($urandom_range(30, 90)),
				$urandom_range(0, 255), 1'b0, $urandom_range(0, 15), $urandom_range(0, 255),
				$urandom_range(0, 255));
			offer_poll(p, 1'b0, '0);
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			$error("result word with nothing outstanding: mood_code %0d event_kind %0d",
				got.mood_code, got.event_kind);
			fails++;
			return;
		end
		want = pending_results.pop_front();
		if (got.mood_code !== want.mood_code) begin
			$error("mood_code expected %0d actual %0d", want.mood_code, got.mood_code);
			fails++;
		end
		if (got.event_kind !== want.event_kind) begin
			$error("event_kind expected %0d actual %0d", want.event_kind, got.event_kind);
			fails++;
		end
		if (got.peak_rate !== want.peak_rate) begin
			$error("peak_rate expected %0h actual %0h", want.peak_rate, got.peak_rate);
			fails++;
		end
		if (got.peak_is_upload !== want.peak_is_upload) begin
			$error("peak_is_upload expected %0d actual %0d", want.peak_is_upload,
				got.peak_is_upload);
			fails++;
		end
	endtask

	// Result side: sample between edges, take at the edge, then pick the next stall
	always begin
		@(negedge clk);
		result_ready = out_valid && !out_stall;
		result_word = {mood_code, event_kind, peak_rate, peak_is_upload};
		@(posedge clk);
		if (result_ready === 1'b1) check_result(result_word);
		if (!held_once && results_seen >= 60) begin
			held_once = 1'b1;
			hold_left = 150;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (free_left > 0) begin
			free_left--;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			free_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
			stall_left = ($urandom_range(0, 6) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
			out_stall <= 1'b0;
		end
	end

	// Watchdog: end the run when no word moves on either side for too long
	initial begin
		int moved_seen;
		int stuck;
		moved_seen = 0;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(negedge clk);
			if (polls_taken + results_seen != moved_seen) begin
				moved_seen = polls_taken + results_seen;
				stuck = 0;
			end else begin
				stuck++;
			end
		end
		$display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		plan_row_t plan[$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		{link_online, down_rate, up_rate, rsrp_raw, sinr_raw, recent_activity,
			carrier_count, client_count, radio_tech_code} = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		// Predictor state after reset
		cfg.busy_enter_rate = RST_BUSY_ENTER;
		cfg.busy_exit_rate = RST_BUSY_EXIT;
		cfg.idle_rate_limit = RST_IDLE_RATE;
		cfg.idle_polls_to_sleep = RST_IDLE_POLLS;
		cfg.stable_polls = RST_STABLE;
		is_busy = 1'b0;
		signal_band = MOOD_HAPPY;
		rsrp_hold = RST_HELD_RSRP;
		sinr_hold = RST_HELD_SINR;
		quiet_polls = '0;
		face_mood = MOOD_HAPPY;
		pending_mood = MOOD_HAPPY;
		pending_run = '0;
		primed = 1'b0;
		link_was_up = 1'b1;
		prev_carriers = '0;
		clients_before = '0;
		prev_radio = '0;

		// Directed words at reset settings; typed rows are first poll, offline, extremes
		plan.push_back({poll_of(1, 0, 0, -90, 10, 1, 2, 3, 5), 1'b1,
			MOOD_HAPPY, EVT_NONE, 32'd0, 1'b0});
		plan.push_back({poll_of(0, 32'hFFFF_FFFF, 0, -90, 10, 0, 2, 3, 5), 1'b1,
			MOOD_OFFLINE, EVT_NONE, 32'hFFFF_FFFF, 1'b0});
		plan.push_back({poll_of(1, 0, 32'hFFFF_FFFF, -90, 10, 1, 2, 3, 5), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -60, 20, 1, 4, 4, 5), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 200000, 100000, -60, 20, 0, 7, 4, 5), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 60000, 59999, -60, 20, 0, 1, 4, 5), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 60000, 60000, -60, 20, 0, 0, 4, 5), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 0, 0, -60, 20, 0, 3, 4, 9), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 0, 0, -29, 127, 0, 3, 4, 0), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 0, 0, -151, -128, 0, 3, 4, 7), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 0, 0, 32767, -128, 0, 3, 2, 7), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 0, 0, -32768, 0, 0, 15, 255, 255), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 0, 0, -150, -128, 1, 15, 10, 255), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 1, 2, -120, -5, 1, 15, 10, 255), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 1, 2, -120, -5, 1, 15, 10, 255), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 1, 2, -120, -5, 1, 15, 10, 255), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 1, 2, -100, 8, 1, 15, 10, 255), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 1, 2, -99, 8, 1, 15, 10, 255), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 1, 2, -30, 0, 1, 15, 10, 255), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 1, 2, -96, 9, 1, 15, 10, 255), 1'b0, 39'd0});
		plan.push_back({poll_of(0, 5, 5, -96, 9, 1, 15, 11, 255), 1'b1,
			MOOD_OFFLINE, EVT_MORE_CLIENTS, 32'd5, 1'b0});
		plan.push_back({poll_of(1, 5, 5, -96, 9, 0, 14, 12, 1), 1'b0, 39'd0});
		plan.push_back({poll_of(1, 7, 9, -96, 9, 0, 14, 12, 1), 1'b0, 39'd0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) offer_poll(plan[k].poll, plan[k].typed, plan[k].want);
		random_polls(60);
		settle();

		apply_settings(33'd1000, 33'd500, 33'd800, 14'd3, 4'd1);
		random_polls(80);
		settle();

		// Never busy after the first poll, every rate under the idle limit, sleepy from zero
		apply_settings(RATE_TOP, RATE_TOP, RATE_TOP, 14'd0, 4'd0);
		random_polls(60);
		settle();

		apply_settings(33'd0, 33'd1, 33'd0, 14'd9999, 4'd15);
		random_polls(80);
		settle();

		apply_settings(RATE_TOP, RATE_TOP, RATE_TOP, 14'd30, 4'd1);
		quiet_stretch(QUIET_RUN);
		settle();

		apply_settings(33'd300000, 33'd100000, 33'd200000, 14'd5, 4'd3);
		random_polls(80);
		settle();

		repeat (8) @(posedge clk);
		$display("Summary: %0d polls sent and %0d result words checked across six register",
			polls_taken, results_seen);
		$display("settings, with a long output hold-off and a %0d-poll quiet stretch.", QUIET_RUN);
		if (fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
